FILE: hw/rtl/aebc_pkg.sv
`default_nettype none

package aebc_pkg;

    localparam int NUM_BANKS_DEF = 3;

    localparam int BANK_W  = 2;
    localparam int CTRL_W  = 7;
    localparam int VAL_W   = 7;
    localparam int CHAN_W  = 5;
    localparam int LONG_W  = 12;
    localparam int SHORT_W = 7;
    localparam int ACCEL_W = 6;
    localparam int DEB_W   = 16;
    localparam int CTRLS_W = 21;
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 4;
    localparam int POS_W   = 16;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam int MAG_W     = 16;
    localparam int NUM_W     = 18;
    localparam int PROD_W    = 33;
    localparam int DIV_CNT_W = 6;
    localparam int SUM_W     = 35;

    localparam logic [LONG_W-1:0]  LONG_RST  = LONG_W'(200);
    localparam logic [SHORT_W-1:0] SHORT_RST = SHORT_W'(5);
    localparam logic [ACCEL_W-1:0] ACCEL_RST = ACCEL_W'(10);
    localparam logic [DEB_W-1:0]   DEB_RST   = DEB_W'(200);
    localparam logic [CHAN_W-1:0]  CHAN_RST  = CHAN_W'(1);
    localparam logic [CTRLS_W-1:0] CTRLS_RST = CTRLS_W'(49409);

    localparam logic [VAL_W-1:0] VAL_MAX = VAL_W'(127);

    localparam logic [CFG_IDX_W-1:0] REG_LONG  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SHORT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DEB   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CHAN  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CTRLS = CFG_IDX_W'(5);

    typedef struct packed {
        logic [LONG_W-1:0]  long_ms;
        logic [SHORT_W-1:0] short_ms;
        logic [ACCEL_W-1:0] accel;
        logic [DEB_W-1:0]   deb;
        logic [CHAN_W-1:0]  chan;
        logic [CTRLS_W-1:0] ctrls;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_POS,
        OP_SETUP,
        OP_NUMER,
        OP_MUL,
        OP_DIV,
        OP_ACC,
        OP_UNIT,
        OP_PLAIN,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_SAME,
        C_SLOW,
        C_FLAT,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] PC_WAIT   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_POS    = PC_W'(1);
    localparam logic [PC_W-1:0] PC_T_SAME = PC_W'(2);
    localparam logic [PC_W-1:0] PC_T_SLOW = PC_W'(3);
    localparam logic [PC_W-1:0] PC_T_FLAT = PC_W'(4);
    localparam logic [PC_W-1:0] PC_SETUP  = PC_W'(5);
    localparam logic [PC_W-1:0] PC_NUMER  = PC_W'(6);
    localparam logic [PC_W-1:0] PC_MUL    = PC_W'(7);
    localparam logic [PC_W-1:0] PC_DIV    = PC_W'(8);
    localparam logic [PC_W-1:0] PC_ACC    = PC_W'(9);
    localparam logic [PC_W-1:0] PC_UNIT   = PC_W'(10);
    localparam logic [PC_W-1:0] PC_PLAIN  = PC_W'(11);
    localparam logic [PC_W-1:0] PC_EMIT   = PC_W'(12);

    typedef struct packed {
        t_op             op;
        t_cond           wait_c;
        t_cond           br_c;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic same;
        logic slow;
        logic flat;
        logic div_more;
        logic out_busy;
    } t_flags;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_uop;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, wait_c: C_NEVER, br_c: C_ALWAYS, target: PC_WAIT};
        case (pc)
            PC_WAIT:   w = '{op: OP_LOAD,  wait_c: C_NO_INPUT, br_c: C_NEVER,    target: PC_WAIT};
            PC_POS:    w = '{op: OP_POS,   wait_c: C_NEVER,    br_c: C_NEVER,    target: PC_WAIT};
            PC_T_SAME: w = '{op: OP_NOP,   wait_c: C_NEVER,    br_c: C_SAME,     target: PC_WAIT};
            PC_T_SLOW: w = '{op: OP_NOP,   wait_c: C_NEVER,    br_c: C_SLOW,     target: PC_PLAIN};
            PC_T_FLAT: w = '{op: OP_NOP,   wait_c: C_NEVER,    br_c: C_FLAT,     target: PC_UNIT};
            PC_SETUP:  w = '{op: OP_SETUP, wait_c: C_NEVER,    br_c: C_NEVER,    target: PC_WAIT};
            PC_NUMER:  w = '{op: OP_NUMER, wait_c: C_NEVER,    br_c: C_NEVER,    target: PC_WAIT};
            PC_MUL:    w = '{op: OP_MUL,   wait_c: C_NEVER,    br_c: C_NEVER,    target: PC_WAIT};
            PC_DIV:    w = '{op: OP_DIV,   wait_c: C_NEVER,    br_c: C_DIV_MORE, target: PC_DIV};
            PC_ACC:    w = '{op: OP_ACC,   wait_c: C_NEVER,    br_c: C_ALWAYS,   target: PC_EMIT};
            PC_UNIT:   w = '{op: OP_UNIT,  wait_c: C_NEVER,    br_c: C_ALWAYS,   target: PC_EMIT};
            PC_PLAIN:  w = '{op: OP_PLAIN, wait_c: C_NEVER,    br_c: C_NEVER,    target: PC_WAIT};
            PC_EMIT:   w = '{op: OP_EMIT,  wait_c: C_OUT_BUSY, br_c: C_ALWAYS,   target: PC_WAIT};
            default:   w = '{op: OP_NOP,   wait_c: C_NEVER,    br_c: C_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/aebc_sequencer.sv
`default_nettype none

module aebc_sequencer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  aebc_pkg::t_flags     i_flags,
    output aebc_pkg::t_uop       o_uop,
    output logic                 o_in_ready
);

    logic [aebc_pkg::PC_W-1:0] r_pc;
    logic [aebc_pkg::PC_W-1:0] n_pc;
    aebc_pkg::t_uword          w_word;
    logic                      w_hold;
    logic                      w_branch;

    function automatic logic cond_true(input aebc_pkg::t_cond c, input logic in_valid,
                                       input aebc_pkg::t_flags f);
        logic v;
        v = 1'b0;
        case (c)
            aebc_pkg::C_NEVER:    v = 1'b0;
            aebc_pkg::C_ALWAYS:   v = 1'b1;
            aebc_pkg::C_NO_INPUT: v = !in_valid;
            aebc_pkg::C_SAME:     v = f.same;
            aebc_pkg::C_SLOW:     v = f.slow;
            aebc_pkg::C_FLAT:     v = f.flat;
            aebc_pkg::C_DIV_MORE: v = f.div_more;
            aebc_pkg::C_OUT_BUSY: v = f.out_busy;
            default:              v = 1'b0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_word   = aebc_pkg::ucode(r_pc);
        w_hold   = cond_true(w_word.wait_c, i_in_valid, i_flags);
        w_branch = cond_true(w_word.br_c, i_in_valid, i_flags);
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_branch) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
        o_uop.op   = w_word.op;
        o_uop.fire = !w_hold;
    end

    assign o_in_ready = i_rst_n && (r_pc == aebc_pkg::PC_WAIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= aebc_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/aebc_datapath.sv
`default_nettype none

module aebc_datapath #(
    parameter int NUM_BANKS = aebc_pkg::NUM_BANKS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  aebc_pkg::t_cfg                       i_cfg,
    input  aebc_pkg::t_uop                       i_uop,
    input  wire logic [aebc_pkg::TIME_W-1:0]     i_now,
    input  wire logic [aebc_pkg::STEP_W-1:0]     i_steps,
    input  wire logic                            i_level,
    input  wire logic                            i_out_ready,
    output aebc_pkg::t_flags                     o_flags,
    output logic                                 o_out_valid,
    output logic [aebc_pkg::OUT_DATA_W-1:0]      o_out_data
);

    localparam int TW = aebc_pkg::TIME_W;
    localparam int PW = aebc_pkg::POS_W;
    localparam int BW = aebc_pkg::BANK_W;
    localparam int VW = aebc_pkg::VAL_W;
    localparam int LW = aebc_pkg::LONG_W;
    localparam int SW = aebc_pkg::SHORT_W;
    localparam int QW = aebc_pkg::PROD_W;
    localparam int XW = aebc_pkg::SUM_W;

    // Input item and per-item working registers.
    logic [TW-1:0]                    r_now;
    logic [aebc_pkg::STEP_W-1:0]      r_steps;
    logic                             r_level;
    logic [PW-1:0]                    r_cand;
    logic [TW-1:0]                    r_dt;
    logic [LW-1:0]                    r_ldt;
    logic [LW-1:0]                    r_den;
    logic [aebc_pkg::NUM_W-1:0]       r_num;
    logic [QW-1:0]                    r_quo;
    logic [LW-1:0]                    r_rem;
    logic [aebc_pkg::DIV_CNT_W-1:0]   r_cnt;

    // Block state.
    logic [PW-1:0] r_pos;
    logic [VW-1:0] r_last_sent;
    logic [TW-1:0] r_last_move;
    logic          r_last_button;
    logic [TW-1:0] r_press_time;
    logic [BW-1:0] r_bank;
    logic [VW-1:0] r_store [NUM_BANKS];

    logic                             r_out_valid;
    logic [aebc_pkg::CTRL_W-1:0]      r_out_ctrl;
    logic [VW-1:0]                    r_out_val;
    logic [aebc_pkg::CHAN_W-1:0]      r_out_chan;
    logic [BW-1:0]                    r_out_bank;

    logic [PW:0]                      w_pos_sum;
    logic [PW-1:0]                    w_pos_sat;
    logic [TW-1:0]                    w_gap;
    logic                             w_press;
    logic [BW-1:0]                    w_next_bank;
    logic [PW:0]                      w_diff;
    logic                             w_neg;
    logic [PW:0]                      w_diff_abs;
    logic [aebc_pkg::MAG_W-1:0]       w_mag;
    logic [LW-1:0]                    w_dte;
    logic [aebc_pkg::SHORT_W:0]       w_accm1;
    logic [19:0]                      w_nprod;
    logic [20:0]                      w_nsum;
    logic [aebc_pkg::MAG_W+aebc_pkg::NUM_W-1:0] w_mprod;
    logic [LW:0]                      w_trial;
    logic                             w_ge;
    logic [XW-1:0]                    w_qext;
    logic [XW-1:0]                    w_acc_sum;
    logic [XW-1:0]                    w_unit_sum;
    logic [VW-1:0]                    w_acc_clamp;
    logic [VW-1:0]                    w_unit_clamp;
    logic [VW-1:0]                    w_plain_clamp;
    logic                             w_do;

    function automatic logic [VW-1:0] clamp_val(input logic [XW-1:0] v);
        logic [VW-1:0] c;
        if (v[XW-1]) begin
            c = '0;
        end else if (|v[XW-2:VW]) begin
            c = aebc_pkg::VAL_MAX;
        end else begin
            c = v[VW-1:0];
        end
        return c;
    endfunction

    always_comb begin
        w_do = i_uop.fire;

        w_pos_sum = {r_pos[PW-1], r_pos} + {{(PW+1-aebc_pkg::STEP_W){r_steps[3]}}, r_steps};
        if (w_pos_sum[PW] != w_pos_sum[PW-1]) begin
            w_pos_sat = w_pos_sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end else begin
            w_pos_sat = w_pos_sum[PW-1:0];
        end

        w_gap   = r_now - r_press_time;
        w_press = !r_level && r_last_button
                  && (w_gap > {{(TW-aebc_pkg::DEB_W){1'b0}}, i_cfg.deb});
        w_next_bank = (r_bank == BW'(NUM_BANKS - 1)) ? '0 : r_bank + 1'b1;

        w_diff     = {r_cand[PW-1], r_cand} - {{(PW+1-VW){1'b0}}, r_last_sent};
        w_neg      = w_diff[PW];
        w_diff_abs = w_neg ? (~w_diff + 1'b1) : w_diff;
        w_mag      = w_diff_abs[aebc_pkg::MAG_W-1:0];

        w_dte = (r_dt < {{(TW-SW){1'b0}}, i_cfg.short_ms})
                ? {{(LW-SW){1'b0}}, i_cfg.short_ms} : r_dt[LW-1:0];

        w_accm1 = {1'b0, i_cfg.accel} - 1'b1;
        w_nprod = $signed(w_accm1) * $signed({1'b0, r_ldt});
        w_nsum  = {w_nprod[19], w_nprod} + {{(21-LW){1'b0}}, r_den};

        w_mprod = w_mag * r_num;

        w_trial = {r_rem, r_quo[QW-1]};
        w_ge    = (w_trial >= {1'b0, r_den});

        w_qext     = {{(XW-QW){1'b0}}, r_quo};
        w_acc_sum  = {{(XW-PW){r_cand[PW-1]}}, r_cand}
                     + (w_neg ? (~w_qext + 1'b1) : w_qext);
        w_unit_sum = {{(XW-PW){r_cand[PW-1]}}, r_cand} + {{(XW-PW-1){w_diff[PW]}}, w_diff};
        w_acc_clamp   = clamp_val(w_acc_sum);
        w_unit_clamp  = clamp_val(w_unit_sum);
        w_plain_clamp = clamp_val({{(XW-PW){r_cand[PW-1]}}, r_cand});

        o_flags.same     = (r_cand == {{(PW-VW){1'b0}}, r_last_sent});
        o_flags.slow     = (r_dt >= {{(TW-LW){1'b0}}, i_cfg.long_ms});
        o_flags.flat     = (i_cfg.long_ms <= {{(LW-SW){1'b0}}, i_cfg.short_ms});
        o_flags.div_more = (r_cnt != aebc_pkg::DIV_CNT_W'(QW - 1));
        o_flags.out_busy = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (w_do) begin
            case (i_uop.op)
                aebc_pkg::OP_LOAD: begin
                    r_now   <= i_now;
                    r_steps <= i_steps;
                    r_level <= i_level;
                end
                aebc_pkg::OP_POS: begin
                    r_cand <= w_pos_sat;
                    r_dt   <= r_now - r_last_move;
                end
                aebc_pkg::OP_SETUP: begin
                    r_ldt <= i_cfg.long_ms - w_dte;
                    r_den <= i_cfg.long_ms - {{(LW-SW){1'b0}}, i_cfg.short_ms};
                end
                aebc_pkg::OP_NUMER: begin
                    r_num <= w_nsum[aebc_pkg::NUM_W-1:0];
                end
                aebc_pkg::OP_MUL: begin
                    r_quo <= w_mprod[QW-1:0];
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                aebc_pkg::OP_DIV: begin
                    r_rem <= w_ge ? (w_trial[LW-1:0] - r_den) : w_trial[LW-1:0];
                    r_quo <= {r_quo[QW-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                end
                aebc_pkg::OP_ACC: begin
                    r_cand <= {{(PW-VW){1'b0}}, w_acc_clamp};
                end
                aebc_pkg::OP_UNIT: begin
                    r_cand <= {{(PW-VW){1'b0}}, w_unit_clamp};
                end
                aebc_pkg::OP_PLAIN: begin
                    r_cand <= {{(PW-VW){1'b0}}, w_plain_clamp};
                end
                default: begin
                end
            endcase
        end
        if (w_do && i_uop.op == aebc_pkg::OP_EMIT) begin
            r_out_ctrl <= i_cfg.ctrls[r_bank*aebc_pkg::CTRL_W +: aebc_pkg::CTRL_W];
            r_out_val  <= r_cand[VW-1:0];
            r_out_chan <= i_cfg.chan;
            r_out_bank <= r_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_last_sent   <= '0;
            r_last_move   <= '0;
            r_last_button <= 1'b1;
            r_press_time  <= '0;
            r_bank        <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < NUM_BANKS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (w_do) begin
                case (i_uop.op)
                    aebc_pkg::OP_POS: begin
                        r_last_button <= r_level;
                        if (w_press) begin
                            r_bank       <= w_next_bank;
                            r_pos        <= {{(PW-VW){1'b0}}, r_store[w_next_bank]};
                            r_press_time <= r_now;
                        end else begin
                            r_pos <= w_pos_sat;
                        end
                    end
                    aebc_pkg::OP_ACC: begin
                        r_pos <= {{(PW-VW){1'b0}}, w_acc_clamp};
                    end
                    aebc_pkg::OP_UNIT: begin
                        r_pos <= {{(PW-VW){1'b0}}, w_unit_clamp};
                    end
                    aebc_pkg::OP_EMIT: begin
                        r_store[r_bank] <= r_cand[VW-1:0];
                        r_last_sent     <= r_cand[VW-1:0];
                        r_last_move     <= r_now;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_do && i_uop.op == aebc_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(aebc_pkg::OUT_DATA_W - aebc_pkg::CTRL_W - VW
                            - aebc_pkg::CHAN_W - BW){1'b0}},
                          r_out_bank, r_out_chan, r_out_val, r_out_ctrl};

endmodule

`default_nettype wire

FILE: hw/rtl/accelerated_encoder_bank_controller.sv
// Encoder bank controller with speed acceleration.
// Poll items arrive on the slave stream; each one may give one control-change
// item on the master stream. Registers are written through a plain write port
// (enable, index, data); the user is to write them only while the block is
// idle, which the block does not enforce. An item matching the last value
// sent ends after the compare step with no result. An accelerated item also
// runs setup, numerator, multiply, divide and accumulate steps before emit:
// a microcoded sequencer steps one shared datapath, and the restoring divider
// by the cutoff span takes one quotient bit per cycle over 33 bits. The block
// takes one poll at a time; it is ready again once the previous result sits
// in the output register, so a poll may be taken while a result still waits.
// If the receiver stalls, the result is held unchanged and the next result
// waits in the sequencer until the output register frees.
// Reset is synchronous and active low: it loads the register defaults, clears
// the position, bank and stored bank values, and marks the button released.
`default_nettype none

module accelerated_encoder_bank_controller #(
    parameter int NUM_BANKS = aebc_pkg::NUM_BANKS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // now_ms [31:0], encoder_steps [35:32], button_level [36], zero [39:37]
    input  wire logic [aebc_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // controller [6:0], cc_value [13:7], channel [18:14], bank [20:19], zero [23:21]
    output logic [aebc_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [aebc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [aebc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    aebc_pkg::t_cfg   r_cfg;
    aebc_pkg::t_flags w_flags;
    aebc_pkg::t_uop   w_uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_ms  <= aebc_pkg::LONG_RST;
            r_cfg.short_ms <= aebc_pkg::SHORT_RST;
            r_cfg.accel    <= aebc_pkg::ACCEL_RST;
            r_cfg.deb      <= aebc_pkg::DEB_RST;
            r_cfg.chan     <= aebc_pkg::CHAN_RST;
            r_cfg.ctrls    <= aebc_pkg::CTRLS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aebc_pkg::REG_LONG:  r_cfg.long_ms  <= i_cfg_wdata[aebc_pkg::LONG_W-1:0];
                aebc_pkg::REG_SHORT: r_cfg.short_ms <= i_cfg_wdata[aebc_pkg::SHORT_W-1:0];
                aebc_pkg::REG_ACCEL: r_cfg.accel    <= i_cfg_wdata[aebc_pkg::ACCEL_W-1:0];
                aebc_pkg::REG_DEB:   r_cfg.deb      <= i_cfg_wdata[aebc_pkg::DEB_W-1:0];
                aebc_pkg::REG_CHAN:  r_cfg.chan     <= i_cfg_wdata[aebc_pkg::CHAN_W-1:0];
                aebc_pkg::REG_CTRLS: r_cfg.ctrls    <= i_cfg_wdata[aebc_pkg::CTRLS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    aebc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_flags    (w_flags),
        .o_uop      (w_uop),
        .o_in_ready (o_s_axis_tready)
    );

    aebc_datapath #(
        .NUM_BANKS (NUM_BANKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_uop       (w_uop),
        .i_now       (i_s_axis_tdata[31:0]),
        .i_steps     (i_s_axis_tdata[35:32]),
        .i_level     (i_s_axis_tdata[36]),
        .i_out_ready (i_m_axis_tready),
        .o_flags     (w_flags),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
